// File: rtl/tas_pkg.sv
`timescale 1ns / 1ps

package tas_pkg;

    localparam int KEY_BITS = 64;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

endpackage

// File: rtl/transaction_access_set_unit.sv
`timescale 1ns / 1ps

// Access set of one transaction: a table of up to CAPACITY entries keyed by a
// 64-bit address, each with an optional data word of WORD_BITS bits.
// Input channel (i_in_valid / o_in_ready) carries one command beat: add or
// update, lookup, or clear. Output channel (o_out_valid / i_out_ready) returns
// exactly one result beat per command, in command order.
// Entries are always packed at the low end of the table, so the fill count
// alone tells which entries are live and where the next insert goes.
// Timing: an add or lookup scans the live entries through the single-port
// read of the entry RAM, one entry per cycle, and stops at the first match.
// Each entry read is compared with the key as it returns from the RAM; on a
// match, or once every live entry has been compared, the unit goes to the
// finish state, which clear and the unused code enter without a scan.
// The next command is taken in the cycle after the result is registered, so
// a new command is not accepted until the previous one has finished.
// When the receiver stalls, one finished result waits in the output register
// while the next command is accepted and scanned; that command then holds
// until the waiting result has been taken.
// Reset empties the table at once by clearing the fill count; no sweep of
// the RAM is needed and a command may be sent in the first cycle after reset.
module transaction_access_set_unit #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_address,
    input  logic        i_value_given,
    input  logic [63:0] i_data_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_value_present,
    output logic [63:0] o_read_word
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KB = tas_pkg::KEY_BITS;
    localparam int RW = KB + 1 + WORD_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    tas_pkg::t_state  r_state, n_state;
    tas_pkg::t_action r_action;
    logic [KB-1:0]        r_key;
    logic                 r_given;
    logic [WORD_BITS-1:0] r_word;
    logic [CW-1:0]        r_fill, n_fill;
    logic [CW-1:0]        r_addr;
    logic                 r_cmp_valid;
    logic [IW-1:0]        r_cmp_idx;
    logic                 r_hit;
    logic [IW-1:0]        r_hit_idx;
    logic                 r_hit_has;
    logic [WORD_BITS-1:0] r_hit_word;
    logic                 r_out_valid;
    tas_pkg::t_status     r_status, n_status;
    logic                 r_present, n_present;
    logic [63:0]          r_rdword, n_rdword;

    logic                 in_accept;
    logic                 issue;
    logic                 match_now;
    logic                 fin_go;
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [RW-1:0]        ram_wdata;
    logic [RW-1:0]        ram_rdata;
    logic [KB-1:0]        rd_key;
    logic                 rd_has;
    logic [WORD_BITS-1:0] rd_word;

    assign in_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == tas_pkg::S_IDLE);

    assign rd_key  = ram_rdata[RW-1 -: KB];
    assign rd_has  = ram_rdata[WORD_BITS];
    assign rd_word = ram_rdata[WORD_BITS-1:0];

    // Reads are pipelined: the entry issued in one cycle is compared in the next.
    assign match_now = r_cmp_valid && (rd_key == r_key);
    assign issue     = (r_state == tas_pkg::S_SCAN) && (r_addr < r_fill) && !match_now;
    assign fin_go    = (r_state == tas_pkg::S_FIN) && (!r_out_valid || i_out_ready);

    tas_ram #(
        .WIDTH (RW),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tas_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_action == tas_pkg::ACT_ADD || i_action == tas_pkg::ACT_LOOKUP) begin
                        n_state = tas_pkg::S_SCAN;
                    end else begin
                        n_state = tas_pkg::S_FIN;
                    end
                end
            end
            tas_pkg::S_SCAN: begin
                if (match_now || (!issue && !r_cmp_valid)) begin
                    n_state = tas_pkg::S_FIN;
                end
            end
            tas_pkg::S_FIN: begin
                if (fin_go) begin
                    n_state = tas_pkg::S_IDLE;
                end
            end
            default: n_state = tas_pkg::S_IDLE;
        endcase
    end

    // Result and table update of the finishing command.
    always_comb begin
        n_status  = tas_pkg::ST_OK;
        n_present = 1'b0;
        n_rdword  = '0;
        n_fill    = r_fill;
        ram_we    = 1'b0;
        ram_waddr = r_hit_idx;
        ram_wdata = {r_key, 1'b1, r_word};
        case (r_action)
            tas_pkg::ACT_ADD: begin
                if (r_hit) begin
                    ram_we = fin_go && r_given;
                end else if (r_fill == FULL_COUNT) begin
                    n_status = tas_pkg::ST_FULL;
                end else begin
                    ram_we    = fin_go;
                    ram_waddr = r_fill[IW-1:0];
                    ram_wdata = {r_key, r_given, r_given ? r_word : '0};
                    n_fill    = r_fill + CW'(1);
                end
            end
            tas_pkg::ACT_LOOKUP: begin
                if (!r_hit) begin
                    n_status = tas_pkg::ST_MISS;
                end else if (r_hit_has) begin
                    n_present = 1'b1;
                    n_rdword  = 64'(r_hit_word);
                end
            end
            tas_pkg::ACT_CLEAR: begin
                n_fill = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tas_pkg::S_IDLE;
            r_fill      <= '0;
            r_addr      <= '0;
            r_cmp_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_addr      <= '0;
                r_cmp_valid <= 1'b0;
                r_hit       <= 1'b0;
            end else begin
                r_cmp_valid <= issue;
                if (issue) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (match_now) begin
                    r_hit <= 1'b1;
                end
            end
            if (fin_go) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action <= tas_pkg::t_action'(i_action);
            r_key    <= i_address;
            r_given  <= i_value_given;
            r_word   <= i_data_word[WORD_BITS-1:0];
        end
        if (issue) begin
            r_cmp_idx <= r_addr[IW-1:0];
        end
        if (match_now) begin
            r_hit_idx  <= r_cmp_idx;
            r_hit_has  <= rd_has;
            r_hit_word <= rd_word;
        end
        if (fin_go) begin
            r_status  <= n_status;
            r_present <= n_present;
            r_rdword  <= n_rdword;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_value_present = r_present;
    assign o_read_word     = r_rdword;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_COUNT)
        else $error("fill count beyond capacity");

    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_valid |-> r_state == tas_pkg::S_SCAN)
        else $error("compare pending outside of scan");

    a_write_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> fin_go)
        else $error("entry write outside of finish");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state != tas_pkg::S_IDLE)
        else $error("accepted command not processed");

    a_no_word_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != tas_pkg::ST_OK) |-> (!r_present && r_rdword == '0))
        else $error("data returned with a failing status");

endmodule

// File: rtl/tas_ram.sv
`timescale 1ns / 1ps

module tas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: bench/access_set_checker.sv
`timescale 1ns / 1ps

module access_set_checker #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_address,
    input  logic        i_value_given,
    input  logic [63:0] i_data_word,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic        i_value_present,
    input  logic [63:0] i_read_word,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_full_seen,
    output int          o_miss_seen,
    output int          o_word_hits
);

    localparam logic [63:0] WORD_MASK =
        (WORD_BITS >= 64) ? {64{1'b1}} : ((64'd1 << WORD_BITS) - 64'd1);

    typedef struct packed {
        tas_pkg::t_status status;
        logic             present;
        logic [63:0]      word;
    } t_access_result;

    // Shadow copy of the access set.
    logic [CAPACITY-1:0] live_map;
    logic [63:0]         key_tab  [CAPACITY];
    logic                has_word [CAPACITY];
    logic [63:0]         word_tab [CAPACITY];

    t_access_result expected_results[$];
    t_access_result want;

    int fail_count;
    int checked_count;
    int full_count;
    int miss_count;
    int word_hit_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();
    assign o_checked    = checked_count;
    assign o_full_seen  = full_count;
    assign o_miss_seen  = miss_count;
    assign o_word_hits  = word_hit_count;

    initial begin
        fail_count     = 0;
        checked_count  = 0;
        full_count     = 0;
        miss_count     = 0;
        word_hit_count = 0;
        live_map       = '0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, exp_val);
        fail_count++;
    endtask

    // Applies one command to the shadow table and returns its result beat.
    function automatic t_access_result apply_access(input tas_pkg::t_action act,
                                                    input logic [63:0] addr,
                                                    input logic given,
                                                    input logic [63:0] data);
        t_access_result r;
        int hit;
        int free_slot;
        r.status  = tas_pkg::ST_OK;
        r.present = 1'b0;
        r.word    = '0;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < CAPACITY; i++) begin
            if (live_map[i] && key_tab[i] == addr && hit < 0) hit = i;
            if (!live_map[i] && free_slot < 0) free_slot = i;
        end
        case (act)
            tas_pkg::ACT_ADD: begin
                if (hit >= 0) begin
                    if (given) begin
                        word_tab[hit] = data & WORD_MASK;
                        has_word[hit] = 1'b1;
                    end
                end else if (free_slot < 0) begin
                    r.status = tas_pkg::ST_FULL;
                end else begin
                    live_map[free_slot] = 1'b1;
                    key_tab[free_slot]  = addr;
                    has_word[free_slot] = given;
                    word_tab[free_slot] = given ? (data & WORD_MASK) : '0;
                end
            end
            tas_pkg::ACT_LOOKUP: begin
                if (hit < 0) begin
                    r.status = tas_pkg::ST_MISS;
                end else if (has_word[hit]) begin
                    r.present = 1'b1;
                    r.word    = word_tab[hit] & WORD_MASK;
                end
            end
            tas_pkg::ACT_CLEAR: live_map = '0;
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            live_map = '0;
            expected_results.delete();
        end else begin
            // Retire first: a command accepted at this edge cannot answer at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding, status",
                                    64'(i_status), 64'(tas_pkg::ST_OK));
                end else begin
                    want = expected_results.pop_front();
                    checked_count++;
                    if (i_status !== want.status)
                        report_mismatch("status", 64'(i_status), 64'(want.status));
                    if (i_value_present !== want.present)
                        report_mismatch("value_present", 64'(i_value_present),
                                        64'(want.present));
                    if (i_read_word !== want.word)
                        report_mismatch("read_word", i_read_word, want.word);
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = apply_access(tas_pkg::t_action'(i_action), i_address, i_value_given,
                                    i_data_word);
                if (want.status == tas_pkg::ST_FULL) full_count++;
                if (want.status == tas_pkg::ST_MISS) miss_count++;
                if (want.present) word_hit_count++;
                expected_results.push_back(want);
            end
        end
    end

endmodule

// File: bench/transaction_access_set_unit_tb.sv
`timescale 1ns / 1ps

module transaction_access_set_unit_tb;

    localparam int CAPACITY    = 16;
    localparam int WORD_BITS   = 64;
    localparam int CMD_TARGET  = 1930;
    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_MAX    = 20;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_action      = tas_pkg::ACT_NONE;
    logic [63:0] i_address     = '0;
    logic        i_value_given = 1'b0;
    logic [63:0] i_data_word   = '0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [1:0]  o_status;
    logic        o_value_present;
    logic [63:0] o_read_word;

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int miss_seen;
    int word_hits;

    int cycle_count = 0;
    int cmds_sent   = 0;
    bit calm        = 1'b0;

    logic [63:0] key_pool [POOL_MAX];
    int          pool_size;

    always #2 i_clk = ~i_clk;

    transaction_access_set_unit #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_address       (i_address),
        .i_value_given   (i_value_given),
        .i_data_word     (i_data_word),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_value_present (o_value_present),
        .o_read_word     (o_read_word)
    );

    access_set_checker #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_address       (i_address),
        .i_value_given   (i_value_given),
        .i_data_word     (i_data_word),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_status        (o_status),
        .i_value_present (o_value_present),
        .i_read_word     (o_read_word),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_seen     (full_seen),
        .o_miss_seen     (miss_seen),
        .o_word_hits     (word_hits)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("transaction_access_set_unit test failed");
            $finish;
        end
    end

    // Receiver side: random stalls, none while the calm window is open.
    always @(negedge i_clk) begin
        if (i_rst_n) i_out_ready = calm || ($urandom_range(0, 99) >= 7);
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {64{1'b1}};
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_cmd(input tas_pkg::t_action act, input logic [63:0] addr,
                            input logic given, input logic [63:0] data);
        while (!calm && $urandom_range(0, 99) < 7) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_action      = act;
        i_address     = addr;
        i_value_given = given;
        i_data_word   = data;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        cmds_sent++;
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Keys of one transaction: near neighbors of a base, random, small and near-all-ones values.
    task automatic fill_key_pool();
        logic [63:0] base;
        base      = {$urandom, $urandom};
        pool_size = $urandom_range(1, POOL_MAX);
        for (int k = 0; k < pool_size; k++) begin
            case ($urandom_range(0, 3))
                0:       key_pool[k] = base ^ (64'd1 << $urandom_range(0, 63));
                1:       key_pool[k] = {$urandom, $urandom};
                2:       key_pool[k] = 64'(k);
                default: key_pool[k] = ~64'(k);
            endcase
        end
    endtask

    task automatic run_transaction();
        int run_len;
        int pick;
        logic [63:0] key;
        run_len = $urandom_range(8, 60);
        if ($urandom_range(0, 99) < 85)
            send_cmd(tas_pkg::ACT_CLEAR, rand_word(), 1'($urandom), rand_word());
        for (int n = 0; n < run_len; n++) begin
            pick = $urandom_range(0, 99);
            key  = key_pool[$urandom_range(0, pool_size - 1)];
            if (pick < 45)
                send_cmd(tas_pkg::ACT_ADD, key, $urandom_range(0, 2) != 0, rand_word());
            else if (pick < 85)
                send_cmd(tas_pkg::ACT_LOOKUP,
                         ($urandom_range(0, 7) == 0) ? rand_word() : key,
                         1'($urandom), rand_word());
            else if (pick < 89)
                send_cmd(tas_pkg::ACT_ADD, rand_word(), 1'($urandom), rand_word());
            else if (pick < 93)
                send_cmd(tas_pkg::ACT_NONE, rand_word(), 1'($urandom), rand_word());
            else if (pick < 96)
                send_cmd(tas_pkg::ACT_CLEAR, rand_word(), 1'($urandom), rand_word());
            else
                send_cmd(tas_pkg::ACT_LOOKUP, rand_word(), 1'($urandom), rand_word());
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_cmd(tas_pkg::ACT_LOOKUP, 64'd0, 1'b0, 64'd0);
        send_cmd(tas_pkg::ACT_ADD, 64'd0, 1'b0, {64{1'b1}});
        send_cmd(tas_pkg::ACT_LOOKUP, 64'd0, 1'b0, 64'd0);
        // An update that brings a word to an entry inserted without one.
        send_cmd(tas_pkg::ACT_ADD, 64'd0, 1'b1, {64{1'b1}});
        send_cmd(tas_pkg::ACT_LOOKUP, 64'd0, 1'b0, 64'd0);
        send_cmd(tas_pkg::ACT_ADD, 64'd0, 1'b0, 64'h1234_5678_9abc_def0);
        send_cmd(tas_pkg::ACT_LOOKUP, 64'd0, 1'b1, {64{1'b1}});
        send_cmd(tas_pkg::ACT_ADD, {64{1'b1}}, 1'b1, 64'd0);
        send_cmd(tas_pkg::ACT_LOOKUP, {64{1'b1}}, 1'b0, 64'd0);
        send_cmd(tas_pkg::ACT_ADD, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 64'h5555_5555_5555_5555);
        send_cmd(tas_pkg::ACT_LOOKUP, 64'h5555_5555_5555_5555, 1'b0, 64'd0);
        send_cmd(tas_pkg::ACT_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'd0);
        send_cmd(tas_pkg::ACT_NONE, {64{1'b1}}, 1'b1, {64{1'b1}});
        send_cmd(tas_pkg::ACT_ADD, 64'h8000_0000_0000_0000, 1'b0, 64'd0);
        send_cmd(tas_pkg::ACT_LOOKUP, 64'h0000_0000_0000_0001, 1'b0, 64'd0);
        send_cmd(tas_pkg::ACT_LOOKUP, 64'h8000_0000_0000_0000, 1'b0, 64'd0);
        send_cmd(tas_pkg::ACT_CLEAR, 64'd0, 1'b0, 64'd0);
        send_cmd(tas_pkg::ACT_LOOKUP, 64'd0, 1'b0, 64'd0);
        send_cmd(tas_pkg::ACT_LOOKUP, {64{1'b1}}, 1'b0, 64'd0);
        send_cmd(tas_pkg::ACT_ADD, {64{1'b1}}, 1'b1, 64'h0123_4567_89ab_cdef);
        send_cmd(tas_pkg::ACT_LOOKUP, {64{1'b1}}, 1'b0, 64'd0);
        drain_results();

        while (cmds_sent < CMD_TARGET) begin
            calm = (cmds_sent >= 700 && cmds_sent < 1000);
            fill_key_pool();
            run_transaction();
            if ($urandom_range(0, 9) == 0) drain_results();
        end
        calm = 1'b0;

        drain_results();
        repeat (CAPACITY + 8) @(negedge i_clk);

        $display("Sent %0d command beats; %0d results checked in %0d cycles.",
                 cmds_sent, checked, cycle_count);
        $display("Seen: %0d inserts into a full table, %0d lookup misses, %0d word hits.",
                 full_seen, miss_seen, word_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("transaction_access_set_unit test passed");
        end else begin
            $display("transaction_access_set_unit test failed");
        end
        $finish;
    end

endmodule
